/* rtl/assert_macros.svh */
// Assertion shorthands used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* rtl/tcons_pkg.sv */
package tcons_pkg;

  localparam int COLUMNS_DEF  = 80;
  localparam int ROWS_DEF     = 25;
  localparam int LINE_MAX_DEF = 256;

  localparam int REQ_W      = 3;
  localparam int CHAR_W     = 8;
  localparam int IDX_W      = 11;
  localparam int CUR_W      = 11;
  localparam int BUF_W      = 8;
  localparam int CELL_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_TEXT_ATTR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ECHO      = 1'd1;

  localparam logic [CHAR_W-1:0] KEY_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] KEY_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_SPACE    = 8'h20;
  localparam logic [CHAR_W-1:0] ATTR_BLANK    = 8'h07;
  localparam logic [CELL_W-1:0] CELL_BLANK    = {ATTR_BLANK, CHAR_SPACE};

  typedef enum logic [REQ_W-1:0] {
    REQ_PRINT      = 3'd0,
    REQ_KEY        = 3'd1,
    REQ_LINE_READ  = 3'd2,
    REQ_CHAR_READ  = 3'd3,
    REQ_CLEAR      = 3'd4,
    REQ_READ_CELL  = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_LINE = 2'd1,
    MODE_CHAR = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_PRINT,
    S_WRAP,
    S_SCROLL,
    S_FLUSH,
    S_CLEAR,
    S_BS,
    S_BS_RD,
    S_BS_WR,
    S_RC,
    S_RC_CAP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [CHAR_W-1:0] text_attribute;
    logic              echo_enable;
  } cfg_t;

  typedef struct packed {
    logic [CUR_W-1:0]  cursor_pos;
    logic [CHAR_W-1:0] cell_char;
    logic [CHAR_W-1:0] cell_attr;
    logic              buf_write;
    logic [BUF_W-1:0]  buf_index;
    logic [CHAR_W-1:0] buf_byte;
    logic              read_done;
    logic              reading;
  } res_t;

endpackage

/* rtl/tcons_ram.sv */
module tcons_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/tcons_ctrl.sv */
module tcons_ctrl #(
  parameter int COLUMNS  = tcons_pkg::COLUMNS_DEF,
  parameter int ROWS     = tcons_pkg::ROWS_DEF,
  parameter int LINE_MAX = tcons_pkg::LINE_MAX_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [tcons_pkg::REQ_W-1:0]          req_type_i,
  input  logic [tcons_pkg::CHAR_W-1:0]         char_code_i,
  input  logic [tcons_pkg::IDX_W-1:0]          cell_index_i,
  input  tcons_pkg::cfg_t                      cfg_i,
  output logic                                 busy_o,
  output logic                                 done_o,
  output tcons_pkg::res_t                      res_o,
  output logic                                 ram_we_o,
  output logic [$clog2(COLUMNS*ROWS)-1:0]      ram_waddr_o,
  output logic [tcons_pkg::CELL_W-1:0]         ram_wdata_o,
  output logic [$clog2(COLUMNS*ROWS)-1:0]      ram_raddr_o,
  input  logic [tcons_pkg::CELL_W-1:0]         ram_rdata_i
);
  import tcons_pkg::*;

  localparam int CELLS      = COLUMNS * ROWS;
  localparam int AW         = $clog2(CELLS);
  localparam int CW         = $clog2(CELLS + 1);
  localparam int COLW       = $clog2(COLUMNS);
  localparam int LINE_LIMIT = ((LINE_MAX - 1) < 255) ? (LINE_MAX - 1) : 255;

  state_e              state_q, state_d;
  logic [AW-1:0]       cnt_q, cnt_d;
  logic                pend_q, pend_d;
  logic [AW-1:0]       wa_q, wa_d;
  logic                blank_q, blank_d;
  logic [CW-1:0]       cursor_q, cursor_d;
  logic [COLW-1:0]     col_q, col_d;
  mode_e               mode_q, mode_d;
  logic [BUF_W-1:0]    lc_q, lc_d;
  logic [REQ_W-1:0]    req_q, req_d;
  logic [CHAR_W-1:0]   ch_q, ch_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [CHAR_W-1:0]   cchar_q, cchar_d;
  logic [CHAR_W-1:0]   cattr_q, cattr_d;
  logic                bw_q, bw_d;
  logic [BUF_W-1:0]    bidx_q, bidx_d;
  logic [CHAR_W-1:0]   bbyte_q, bbyte_d;
  logic                rdone_q, rdone_d;

  logic accept;
  logic key_ignored;
  logic key_bs;
  logic key_drop;
  logic sweep_last;
  logic idx_valid;

  assign accept      = start_i && (state_q == S_IDLE);
  assign key_ignored = (mode_q == MODE_IDLE);
  assign key_bs      = (ch_q == KEY_BACKSPACE);
  // A full line buffer still takes the newline that terminates it.
  assign key_drop    = (mode_q != MODE_CHAR) && (ch_q != KEY_NEWLINE) &&
                       (lc_q >= BUF_W'(LINE_LIMIT));
  assign sweep_last  = (cnt_q == AW'(CELLS - 1));
  assign idx_valid   = (32'(idx_q) < 32'(CELLS));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT:   if (sweep_last) state_d = S_IDLE;
      S_IDLE:   if (start_i) state_d = S_DECODE;
      S_DECODE: begin
        case (req_e'(req_q))
          REQ_PRINT: state_d = S_PRINT;
          REQ_KEY: begin
            if (key_ignored) begin
              state_d = S_DONE;
            end else if (key_bs) begin
              state_d = (lc_q != '0) ? S_BS : S_DONE;
            end else if (key_drop) begin
              state_d = S_DONE;
            end else begin
              state_d = cfg_i.echo_enable ? S_PRINT : S_DONE;
            end
          end
          REQ_CLEAR:     state_d = S_CLEAR;
          REQ_READ_CELL: state_d = idx_valid ? S_RC : S_DONE;
          default:       state_d = S_DONE;
        endcase
      end
      S_PRINT:  state_d = S_WRAP;
      S_WRAP:   state_d = (cursor_q >= CW'(CELLS)) ? S_SCROLL : S_DONE;
      S_SCROLL: if (sweep_last) state_d = S_FLUSH;
      S_FLUSH:  state_d = S_DONE;
      S_CLEAR:  if (sweep_last) state_d = S_DONE;
      S_BS:     state_d = S_BS_RD;
      S_BS_RD:  state_d = S_BS_WR;
      S_BS_WR:  state_d = S_DONE;
      S_RC:     state_d = S_RC_CAP;
      S_RC_CAP: state_d = S_DONE;
      S_DONE:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Outputs and memory port control.
  always_comb begin
    busy_o      = (state_q != S_IDLE);
    done_o      = (state_q == S_DONE);
    ram_we_o    = 1'b0;
    ram_waddr_o = AW'(cursor_q);
    ram_wdata_o = CELL_BLANK;
    ram_raddr_o = AW'(cursor_q);
    case (state_q)
      S_INIT, S_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = cnt_q;
      end
      S_PRINT: begin
        ram_we_o    = (ch_q != KEY_NEWLINE);
        ram_wdata_o = {cfg_i.text_attribute, ch_q};
      end
      S_SCROLL, S_FLUSH: begin
        // Reads run one cell ahead of the writes they feed.
        ram_raddr_o = (cnt_q < AW'(CELLS - COLUMNS)) ? AW'(cnt_q + AW'(COLUMNS)) : cnt_q;
        ram_we_o    = pend_q;
        ram_waddr_o = wa_q;
        ram_wdata_o = blank_q ? CELL_BLANK : ram_rdata_i;
      end
      S_BS_WR: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = {ram_rdata_i[CELL_W-1:CHAR_W], CHAR_SPACE};
      end
      S_RC: ram_raddr_o = AW'(idx_q);
      default: ;
    endcase
  end

  // Datapath updates.
  always_comb begin
    cnt_d    = cnt_q;
    pend_d   = 1'b0;
    wa_d     = wa_q;
    blank_d  = blank_q;
    cursor_d = cursor_q;
    col_d    = col_q;
    mode_d   = mode_q;
    lc_d     = lc_q;
    req_d    = req_q;
    ch_d     = ch_q;
    idx_d    = idx_q;
    cchar_d  = cchar_q;
    cattr_d  = cattr_q;
    bw_d     = bw_q;
    bidx_d   = bidx_q;
    bbyte_d  = bbyte_q;
    rdone_d  = rdone_q;
    case (state_q)
      S_INIT: cnt_d = cnt_q + AW'(1);
      S_IDLE: begin
        if (accept) begin
          req_d   = req_type_i;
          ch_d    = char_code_i;
          idx_d   = cell_index_i;
          cchar_d = '0;
          cattr_d = '0;
          bw_d    = 1'b0;
          bidx_d  = '0;
          bbyte_d = '0;
          rdone_d = 1'b0;
        end
      end
      S_DECODE: begin
        cnt_d = '0;
        case (req_e'(req_q))
          REQ_KEY: begin
            if (!key_ignored && !key_bs && !key_drop) begin
              bw_d   = 1'b1;
              bidx_d = lc_q;
              if (mode_q == MODE_CHAR) begin
                bbyte_d = ch_q;
                mode_d  = MODE_IDLE;
                rdone_d = 1'b1;
              end else if (ch_q == KEY_NEWLINE) begin
                bbyte_d = '0;
                mode_d  = MODE_IDLE;
                rdone_d = 1'b1;
              end else begin
                bbyte_d = ch_q;
                lc_d    = lc_q + BUF_W'(1);
              end
            end
          end
          REQ_LINE_READ: begin
            mode_d = MODE_LINE;
            lc_d   = '0;
          end
          REQ_CHAR_READ: begin
            mode_d = MODE_CHAR;
            lc_d   = '0;
          end
          REQ_CLEAR: begin
            cursor_d = '0;
            col_d    = '0;
          end
          default: ;
        endcase
      end
      S_PRINT: begin
        if (ch_q == KEY_NEWLINE) begin
          cursor_d = cursor_q - CW'(col_q) + CW'(COLUMNS);
          col_d    = '0;
        end else begin
          cursor_d = cursor_q + CW'(1);
          col_d    = (col_q == COLW'(COLUMNS - 1)) ? '0 : col_q + COLW'(1);
        end
      end
      S_WRAP: begin
        if (cursor_q >= CW'(CELLS)) begin
          cursor_d = cursor_q - CW'(COLUMNS);
        end
      end
      S_SCROLL: begin
        pend_d  = 1'b1;
        wa_d    = cnt_q;
        blank_d = (cnt_q >= AW'(CELLS - COLUMNS));
        cnt_d   = cnt_q + AW'(1);
      end
      S_CLEAR: cnt_d = cnt_q + AW'(1);
      S_BS: begin
        lc_d = lc_q - BUF_W'(1);
        if (cursor_q != '0) begin
          cursor_d = cursor_q - CW'(1);
          col_d    = (col_q == '0) ? COLW'(COLUMNS - 1) : col_q - COLW'(1);
        end
      end
      S_RC_CAP: begin
        cchar_d = ram_rdata_i[CHAR_W-1:0];
        cattr_d = ram_rdata_i[CELL_W-1:CHAR_W];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      cnt_q    <= '0;
      pend_q   <= 1'b0;
      cursor_q <= '0;
      col_q    <= '0;
      mode_q   <= MODE_IDLE;
      lc_q     <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      pend_q   <= pend_d;
      cursor_q <= cursor_d;
      col_q    <= col_d;
      mode_q   <= mode_d;
      lc_q     <= lc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wa_q    <= wa_d;
    blank_q <= blank_d;
    req_q   <= req_d;
    ch_q    <= ch_d;
    idx_q   <= idx_d;
    cchar_q <= cchar_d;
    cattr_q <= cattr_d;
    bw_q    <= bw_d;
    bidx_q  <= bidx_d;
    bbyte_q <= bbyte_d;
    rdone_q <= rdone_d;
  end

  always_comb begin
    res_o.cursor_pos = CUR_W'(cursor_q);
    res_o.cell_char  = cchar_q;
    res_o.cell_attr  = cattr_q;
    res_o.buf_write  = bw_q;
    res_o.buf_index  = bidx_q;
    res_o.buf_byte   = bbyte_q;
    res_o.read_done  = rdone_q;
    res_o.reading    = (mode_q != MODE_IDLE);
  end

endmodule

/* rtl/text_console_with_line_input.sv */
// Text console with line-editing keyboard input. A request is taken when
// start_i is high and busy_o is low; its single result appears for exactly one
// cycle with done_o high and cannot be held off. The screen lives in a
// single-write, single-read memory swept by one address counter. After decode,
// a print or echoed key steps through print, wrap and done, a read of a cell on
// the screen through read, capture and done, and a backspace that erases a cell
// through erase, read, write and done; every other request but clear goes
// straight to done, including keys that are ignored, dropped or not echoed and
// reads of cells off the screen. A print or echo that runs off the end of the
// screen scrolls it, one cell moved per cycle, then flushes; clear sweeps all
// ROWS*COLUMNS cells. After reset the block blanks every cell of the screen and
// holds busy_o high meanwhile; configuration writes are taken at any time.
module text_console_with_line_input #(
  parameter int COLUMNS  = tcons_pkg::COLUMNS_DEF,
  parameter int ROWS     = tcons_pkg::ROWS_DEF,
  parameter int LINE_MAX = tcons_pkg::LINE_MAX_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [tcons_pkg::REQ_W-1:0]       req_type_i,
  input  logic [tcons_pkg::CHAR_W-1:0]      char_code_i,
  input  logic [tcons_pkg::IDX_W-1:0]       cell_index_i,
  input  logic                              cfg_we_i,
  input  logic [tcons_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tcons_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output logic                              done_o,
  output logic [tcons_pkg::CUR_W-1:0]       cursor_pos_o,
  output logic [tcons_pkg::CHAR_W-1:0]      cell_char_o,
  output logic [tcons_pkg::CHAR_W-1:0]      cell_attr_o,
  output logic                              buf_write_o,
  output logic [tcons_pkg::BUF_W-1:0]       buf_index_o,
  output logic [tcons_pkg::CHAR_W-1:0]      buf_byte_o,
  output logic                              read_done_o,
  output logic                              reading_o
);
  import tcons_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  cfg_t              cfg_q;
  res_t              res;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.text_attribute <= 8'd10;
      cfg_q.echo_enable    <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TEXT_ATTR: cfg_q.text_attribute <= cfg_wdata_i[CHAR_W-1:0];
        REG_ECHO:      cfg_q.echo_enable    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  tcons_ctrl #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .LINE_MAX (LINE_MAX)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .req_type_i   (req_type_i),
    .char_code_i  (char_code_i),
    .cell_index_i (cell_index_i),
    .cfg_i        (cfg_q),
    .busy_o       (busy_o),
    .done_o       (done_o),
    .res_o        (res),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata)
  );

  tcons_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign cursor_pos_o = res.cursor_pos;
  assign cell_char_o  = res.cell_char;
  assign cell_attr_o  = res.cell_attr;
  assign buf_write_o  = res.buf_write;
  assign buf_index_o  = res.buf_index;
  assign buf_byte_o   = res.buf_byte;
  assign read_done_o  = res.read_done;
  assign reading_o    = res.reading;

endmodule

/* rtl/tcons_chk.sv */
`include "assert_macros.svh"

module tcons_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o,
  input logic read_done_o,
  input logic reading_o,
  input logic buf_write_o
);

  // A result is shown for one cycle only.
  `ASSERT_NXT(a_done_single, clk_i, rst_ni, done_o, !done_o)

  // An accepted transaction keeps the block busy and never completes at once.
  `ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start_i && !busy_o, busy_o && !done_o)

  // The block is free again right after a result.
  `ASSERT_NXT(a_done_frees, clk_i, rst_ni, done_o, !busy_o)

  // Completing a read stores a byte and disarms the read.
  `ASSERT_IMP(a_read_done, clk_i, rst_ni, done_o && read_done_o,
              !reading_o && buf_write_o)

endmodule

bind text_console_with_line_input tcons_chk u_tcons_chk (.*);
